>>> sv/voxel_ray_traversal_assert.svh
// Assertion macros used by the traversal back end.
`ifndef VOXEL_RAY_TRAVERSAL_ASSERT_SVH
`define VOXEL_RAY_TRAVERSAL_ASSERT_SVH

// Check that an implication holds on every clock edge outside reset.
`define VRT_ASSERT_IMPL(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("assertion failed");

// Check that an implication holds in the cycle after its condition.
`define VRT_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("assertion failed");

`endif

>>> sv/vrt_pkg.sv
`timescale 1ns / 1ps
package vrt_pkg;
    localparam int unsigned OriginW = 32;
    localparam int unsigned DirW    = 16;
    localparam int unsigned CellW   = 24;
    localparam int unsigned DistW   = 32;
    localparam int unsigned DeltaW  = 24;
    localparam int unsigned ReachW  = 12;
    localparam int unsigned QuoW    = 23;
    localparam logic [DeltaW-1:0] DeltaSat = '1;
    localparam logic [ReachW-1:0] ReachReset = 12'd2048;

    typedef struct packed {
        logic signed [OriginW-1:0] origin_x;
        logic signed [OriginW-1:0] origin_y;
        logic signed [OriginW-1:0] origin_z;
        logic signed [DirW-1:0]    dir_x;
        logic signed [DirW-1:0]    dir_y;
        logic signed [DirW-1:0]    dir_z;
    } t_ray;

    typedef struct packed {
        logic signed [CellW-1:0] voxel_x;
        logic signed [CellW-1:0] voxel_y;
        logic signed [CellW-1:0] voxel_z;
        logic [ReachW-1:0]       entry_distance;
        logic                    last;
    } t_voxel;

    // One axis set up by the front part.
    typedef struct packed {
        logic [CellW-1:0]  pos;
        logic [DistW-1:0]  bound;
        logic [DeltaW-1:0] delta;
        logic              neg;
    } t_axis;

    typedef struct packed {
        t_axis ax;
        t_axis ay;
        t_axis az;
    } t_setup;
endpackage

>>> sv/vrt_front.sv
`timescale 1ns / 1ps
module vrt_front import vrt_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    output logic   o_full,
    input  t_ray   i_ray,
    output logic   o_valid,
    input  logic   i_ready,
    output t_setup o_setup
);
    typedef enum logic [2:0] {S_IDLE, S_DIV, S_MUL, S_DONE} t_state;

    t_state r_state;
    logic [1:0] r_axis;
    logic [4:0] r_bit;
    logic [QuoW-1:0] r_quo;
    logic [QuoW-1:0] r_rem;
    logic [15:0] r_mag;
    t_ray r_ray;
    t_setup r_setup;

    logic [OriginW-1:0] w_org;
    logic signed [DirW-1:0] w_dir;
    logic [OriginW-1:0] w_sh;
    logic [8:0] w_mul;
    logic [QuoW:0] w_trial;
    logic [DeltaW-1:0] w_delta;
    logic [DeltaW+8:0] w_prod;
    t_axis w_ax;

    always_comb begin
        case (r_axis)
            2'd0: begin w_org = r_ray.origin_x; w_dir = r_ray.dir_x; end
            2'd1: begin w_org = r_ray.origin_y; w_dir = r_ray.dir_y; end
            default: begin w_org = r_ray.origin_z; w_dir = r_ray.dir_z; end
        endcase
        w_sh = w_org + 32'd128;
        w_trial = {r_rem, r_quo[QuoW-1]} - {8'd0, r_mag};
        if (r_mag == 16'd0) w_delta = DeltaSat;
        else w_delta = {1'b0, r_quo};
        if (w_dir[DirW-1]) w_mul = {1'b0, w_sh[7:0]};
        else w_mul = 9'd256 - {1'b0, w_sh[7:0]};
        w_prod = w_delta * w_mul;
        w_ax.pos = w_sh[OriginW-1:8];
        w_ax.delta = w_delta;
        w_ax.neg = w_dir[DirW-1];
        w_ax.bound = {7'd0, w_prod[DeltaW+8:8]};
    end

    assign o_full = (r_state != S_IDLE);
    assign o_valid = (r_state == S_DONE);
    assign o_setup = r_setup;

    // Per axis: restoring divide of 2^22 by |dir|, one quotient bit per cycle, then a multiply step.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_axis <= '0;
            r_bit <= '0;
        end else begin
            case (r_state)
                S_IDLE: if (i_push) begin
                    r_ray <= i_ray;
                    r_axis <= 2'd0;
                    r_state <= S_DIV;
                    r_bit <= '0;
                    r_quo <= 23'h400000;
                    r_rem <= '0;
                    r_mag <= i_ray.dir_x[DirW-1] ? 16'(-i_ray.dir_x) : i_ray.dir_x;
                end
                S_DIV: begin
                    if (w_trial[QuoW]) begin
                        r_rem <= {r_rem[QuoW-2:0], r_quo[QuoW-1]};
                        r_quo <= {r_quo[QuoW-2:0], 1'b0};
                    end else begin
                        r_rem <= w_trial[QuoW-1:0];
                        r_quo <= {r_quo[QuoW-2:0], 1'b1};
                    end
                    r_bit <= r_bit + 5'd1;
                    if (r_bit == 5'(QuoW - 1)) r_state <= S_MUL;
                end
                S_MUL: begin
                    case (r_axis)
                        2'd0: r_setup.ax <= w_ax;
                        2'd1: r_setup.ay <= w_ax;
                        default: r_setup.az <= w_ax;
                    endcase
                    if (r_axis == 2'd2) r_state <= S_DONE;
                    else begin
                        r_axis <= r_axis + 2'd1;
                        r_bit <= '0;
                        r_quo <= 23'h400000;
                        r_rem <= '0;
                        r_state <= S_DIV;
                        if (r_axis == 2'd0)
                            r_mag <= r_ray.dir_y[DirW-1] ? 16'(-r_ray.dir_y) : r_ray.dir_y;
                        else
                            r_mag <= r_ray.dir_z[DirW-1] ? 16'(-r_ray.dir_z) : r_ray.dir_z;
                    end
                end
                S_DONE: if (i_ready) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

>>> sv/vrt_back.sv
`timescale 1ns / 1ps
`include "voxel_ray_traversal_assert.svh"
module vrt_back import vrt_pkg::*; #(
    parameter int unsigned MaxSteps = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [ReachW-1:0] i_reach,
    input  logic              i_valid,
    output logic              o_ready,
    input  t_setup            i_setup,
    output logic              o_empty,
    input  logic              i_pop,
    output t_voxel            o_voxel
);
    localparam int unsigned CntW = $clog2(MaxSteps + 1);

    logic r_busy, r_out_v;
    t_setup r_s;
    logic [DistW-1:0] r_dist;
    logic [CntW-1:0] r_n;
    logic [ReachW-1:0] r_reach;
    t_voxel r_out;

    logic [1:0] w_sel;
    t_axis w_a, w_na;
    logic [DistW:0] w_sum;
    logic w_last, w_go;

    always_comb begin
        if (r_s.ax.bound < r_s.ay.bound && r_s.ax.bound < r_s.az.bound) w_sel = 2'd0;
        else if (r_s.az.bound < r_s.ay.bound) w_sel = 2'd2;
        else w_sel = 2'd1;
        case (w_sel)
            2'd0: w_a = r_s.ax;
            2'd2: w_a = r_s.az;
            default: w_a = r_s.ay;
        endcase
        w_na = w_a;
        w_na.pos = w_a.neg ? w_a.pos - 24'd1 : w_a.pos + 24'd1;
        w_sum = {1'b0, w_a.bound} + {9'd0, w_a.delta};
        w_na.bound = w_sum[DistW] ? '1 : w_sum[DistW-1:0];
        w_last = !(w_a.bound < {20'd0, r_reach}) || (r_n == CntW'(MaxSteps - 1));
        w_go = r_busy && (!r_out_v || i_pop);
    end

    assign o_ready = !r_busy;
    assign o_empty = !r_out_v;
    assign o_voxel = r_out;

    // Emit one voxel per cycle; the walk stalls while the result is held.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            if (w_go) r_out_v <= 1'b1;
            else if (i_pop) r_out_v <= 1'b0;
            if (!r_busy && i_valid) begin
                r_s <= i_setup;
                r_dist <= '0;
                r_n <= '0;
                r_reach <= i_reach;
                r_busy <= (i_reach != '0);
            end else if (w_go) begin
                r_out.voxel_x <= r_s.ax.pos;
                r_out.voxel_y <= r_s.ay.pos;
                r_out.voxel_z <= r_s.az.pos;
                r_out.entry_distance <= r_dist[ReachW-1:0];
                r_out.last <= w_last;
                case (w_sel)
                    2'd0: r_s.ax <= w_na;
                    2'd2: r_s.az <= w_na;
                    default: r_s.ay <= w_na;
                endcase
                r_dist <= w_a.bound;
                r_n <= r_n + CntW'(1);
                if (w_last) r_busy <= 1'b0;
            end
        end
    end

    `VRT_ASSERT_NEXT(a_hold_result, i_clk, i_rst_n, r_out_v && !i_pop, r_out_v && $stable(r_out))
    `VRT_ASSERT_NEXT(a_last_ends_walk, i_clk, i_rst_n, w_go && w_last, !r_busy)
    `VRT_ASSERT_IMPL(a_step_cap, i_clk, i_rst_n, r_busy, r_n < CntW'(MaxSteps))
endmodule

>>> sv/voxel_ray_traversal.sv
`timescale 1ns / 1ps
// channel  | handshake        | payload
// ray in   | i_push / o_full  | i_ray   (t_ray)
// voxel out| o_empty / i_pop  | o_voxel (t_voxel)
// config   | i_cfg_we         | i_cfg_data (max_reach)
// Setup runs three reciprocal divides per ray in turn on one shared divider,
// each followed by a multiply step for its axis; then the setup is handed off.
// The walk then emits one voxel per cycle while pops keep up, up to MaxSteps
// voxels; the back end first loads the setup, then registers the first voxel.
// Reset is synchronous; max_reach returns to 2048.
// A stalled pop holds the walk; the front can set up the next ray meanwhile.
module voxel_ray_traversal import vrt_pkg::*; #(
    parameter int unsigned MaxSteps = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    output logic              o_full,
    input  t_ray              i_ray,
    output logic              o_empty,
    input  logic              i_pop,
    output t_voxel            o_voxel,
    input  logic              i_cfg_we,
    input  logic [ReachW-1:0] i_cfg_data
);
    logic [ReachW-1:0] r_reach;
    logic w_valid, w_ready;
    t_setup w_setup;

    // hold the reach register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_reach <= ReachReset;
        else if (i_cfg_we) r_reach <= i_cfg_data;
    end

    vrt_front u_front (
        .i_clk, .i_rst_n, .i_push, .o_full, .i_ray,
        .o_valid(w_valid), .i_ready(w_ready), .o_setup(w_setup)
    );

    vrt_back #(.MaxSteps(MaxSteps)) u_back (
        .i_clk, .i_rst_n, .i_reach(r_reach), .i_valid(w_valid), .o_ready(w_ready),
        .i_setup(w_setup), .o_empty, .i_pop, .o_voxel
    );
endmodule

>>> tb/voxel_walk_checker.sv
`timescale 1ns / 1ps
module voxel_walk_checker import vrt_pkg::*; #(
    parameter int unsigned MaxSteps = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic              i_full,
    input  t_ray              i_ray,
    input  logic              i_empty,
    input  logic              i_pop,
    input  t_voxel            i_voxel,
    input  logic              i_cfg_we,
    input  logic [ReachW-1:0] i_cfg_data,
    output int                o_errors,
    output int                o_pending,
    output int                o_voxels_seen
);
    t_voxel expected_voxels[$];
    logic [ReachW-1:0] reach_limit;

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t: %s", $realtime, what);
        o_errors++;
    endtask

    // Set up one axis: starting cell, first crossing, spacing, direction.
    function automatic void axis_setup(input logic signed [OriginW-1:0] org,
                                       input logic signed [DirW-1:0] dir,
                                       output logic [CellW-1:0] pos,
                                       output logic [DistW-1:0] bound,
                                       output logic [DeltaW-1:0] delta,
                                       output logic neg);
        longint shifted;
        longint mag;
        longint spacing;
        longint frac;
        shifted = longint'(org) + 128;
        frac = shifted & 255;
        pos = CellW'((shifted - frac) >>> 8);
        mag = (dir < 0) ? -longint'(dir) : longint'(dir);
        spacing = (mag == 0) ? 64'hFFFFFF : ((64'd1 << 22) / mag);
        if (spacing > 64'hFFFFFF) spacing = 64'hFFFFFF;
        delta = DeltaW'(spacing);
        neg = (dir < 0);
        bound = neg ? DistW'((frac * spacing) >> 8) : DistW'(((256 - frac) * spacing) >> 8);
    endfunction

    // Walk the grid for one ray and queue each voxel it visits.
    task automatic predict_walk(input t_ray r);
        logic [CellW-1:0]  pos[3];
        logic [DistW-1:0]  bound[3];
        logic [DeltaW-1:0] delta[3];
        logic              neg[3];
        longint walked;
        longint sum;
        int n;
        int a;
        t_voxel v;
        axis_setup(r.origin_x, r.dir_x, pos[0], bound[0], delta[0], neg[0]);
        axis_setup(r.origin_y, r.dir_y, pos[1], bound[1], delta[1], neg[1]);
        axis_setup(r.origin_z, r.dir_z, pos[2], bound[2], delta[2], neg[2]);
        walked = 0;
        n = 0;
        while (walked < reach_limit && n < MaxSteps) begin
            v.voxel_x = pos[0];
            v.voxel_y = pos[1];
            v.voxel_z = pos[2];
            v.entry_distance = ReachW'(walked);
            // x steps only when strictly nearest; z beats y only when strictly below
            if (bound[0] < bound[1] && bound[0] < bound[2]) a = 0;
            else if (bound[2] < bound[1]) a = 2;
            else a = 1;
            pos[a] = neg[a] ? pos[a] - 1'b1 : pos[a] + 1'b1;
            walked = bound[a];
            sum = longint'(bound[a]) + longint'(delta[a]);
            bound[a] = (sum > 64'hFFFFFFFF) ? 32'hFFFFFFFF : DistW'(sum);
            n++;
            v.last = !(walked < reach_limit) || n >= MaxSteps;
            expected_voxels.push_back(v);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            reach_limit <= ReachReset;
            expected_voxels.delete();
        end else begin
            // predict before the register changes at this edge
            if (i_push && !i_full) predict_walk(i_ray);
            if (i_cfg_we) reach_limit <= i_cfg_data;
            if (i_pop && !i_empty) begin
                o_voxels_seen++;
                if (expected_voxels.size() == 0) begin
                    report_mismatch("voxel with none expected");
                end else begin
                    t_voxel e;
                    e = expected_voxels.pop_front();
                    if (i_voxel.voxel_x !== e.voxel_x)
                        report_mismatch($sformatf("voxel_x %0d exp %0d",
                                                  i_voxel.voxel_x, e.voxel_x));
                    if (i_voxel.voxel_y !== e.voxel_y)
                        report_mismatch($sformatf("voxel_y %0d exp %0d",
                                                  i_voxel.voxel_y, e.voxel_y));
                    if (i_voxel.voxel_z !== e.voxel_z)
                        report_mismatch($sformatf("voxel_z %0d exp %0d",
                                                  i_voxel.voxel_z, e.voxel_z));
                    if (i_voxel.entry_distance !== e.entry_distance)
                        report_mismatch($sformatf("entry_distance %0d exp %0d",
                                                  i_voxel.entry_distance, e.entry_distance));
                    if (i_voxel.last !== e.last)
                        report_mismatch($sformatf("last %0b exp %0b",
                                                  i_voxel.last, e.last));
                end
            end
        end
        o_pending <= expected_voxels.size();
    end

    initial begin
        o_errors = 0;
        o_voxels_seen = 0;
        o_pending = 0;
    end
endmodule

>>> tb/voxel_ray_traversal_tb.sv
`timescale 1ns / 1ps
module voxel_ray_traversal_tb;
    import vrt_pkg::*;

    logic              clk;
    logic              rst_n;
    logic              push;
    logic              full;
    t_ray              ray;
    logic              empty;
    logic              pop;
    t_voxel            voxel;
    logic              cfg_we;
    logic [ReachW-1:0] cfg_data;
    int                errors;
    int                pending;
    int                voxels_seen;
    int                rays_sent;
    bit                pop_hold;

    voxel_ray_traversal u_top (
        .i_clk     (clk),
        .i_rst_n   (rst_n),
        .i_push    (push),
        .o_full    (full),
        .i_ray     (ray),
        .o_empty   (empty),
        .i_pop     (pop),
        .o_voxel   (voxel),
        .i_cfg_we  (cfg_we),
        .i_cfg_data(cfg_data)
    );

    voxel_walk_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_push       (push),
        .i_full       (full),
        .i_ray        (ray),
        .i_empty      (empty),
        .i_pop        (pop),
        .i_voxel      (voxel),
        .i_cfg_we     (cfg_we),
        .i_cfg_data   (cfg_data),
        .o_errors     (errors),
        .o_pending    (pending),
        .o_voxels_seen(voxels_seen)
    );

    always begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Mostly short gaps, now and then a long one, sometimes none.
    function automatic int gap_len();
        int p;
        p = $urandom_range(99);
        if (p < 40) return 0;
        if (p < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic logic signed [DirW-1:0] rand_dir();
        int p;
        p = $urandom_range(9);
        if (p == 0) return '0;
        if (p == 1) return $urandom_range(1) ? 16'sd16384 : -16'sd16384;
        if (p == 2) return DirW'($urandom());  // full 16-bit noise, out of range too
        return DirW'(int'($urandom_range(32768)) - 16384);
    endfunction

    function automatic logic signed [OriginW-1:0] rand_origin();
        if ($urandom_range(4) == 0) return OriginW'($urandom());
        return OriginW'(int'($urandom_range(1 << 20)) - (1 << 19));
    endfunction

    // Hand one ray over, then, unless the gap is zero, pause a random while with push low.
    task automatic send_ray(input t_ray r);
        int g;
        push <= 1'b1;
        ray  <= r;
        @(posedge clk);
        while (full) @(posedge clk);
        rays_sent++;
        g = gap_len();
        @(negedge clk);
        if (g > 0) begin
            push <= 1'b0;
            repeat (g) @(negedge clk);
        end
    endtask

    task automatic send_dir(input logic signed [OriginW-1:0] ox, oy, oz,
                            input logic signed [DirW-1:0] dx, dy, dz);
        t_ray r;
        r.origin_x = ox; r.origin_y = oy; r.origin_z = oz;
        r.dir_x = dx; r.dir_y = dy; r.dir_z = dz;
        send_ray(r);
    endtask

    task automatic send_random();
        send_dir(rand_origin(), rand_origin(), rand_origin(),
                 rand_dir(), rand_dir(), rand_dir());
    endtask

    // Drain every expected voxel, let the walk settle, then load a new reach.
    task automatic set_reach(input logic [ReachW-1:0] value);
        push <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (200) @(posedge clk);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Receiver: random stalls on pop, with stretches of steady draining.
    always @(negedge clk) begin
        if (!rst_n || pop_hold) begin
            pop <= 1'b0;
        end else if ($urandom_range(99) < 8) begin
            pop <= 1'b0;
            repeat (gap_len()) @(negedge clk);
        end else begin
            pop <= 1'b1;
        end
    end

    initial begin
        int k;
        push = 1'b0; pop = 1'b0; ray = '0; cfg_we = 1'b0; cfg_data = '0;
        rst_n = 1'b0; rays_sent = 0; pop_hold = 0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed rays at reset reach: axis-aligned both ways, diagonal ties,
        // a zero direction, extreme origins and out-of-range magnitudes.
        send_dir(0, 0, 0, 16384, 0, 0);
        send_dir(0, 0, 0, -16384, 0, 0);
        send_dir(0, 0, 0, 0, 16384, 0);
        send_dir(0, 0, 0, 0, -16384, 0);
        send_dir(0, 0, 0, 0, 0, 16384);
        send_dir(0, 0, 0, 0, 0, -16384);
        send_dir(0, 0, 0, 9459, 9459, 9459);      // three-way tie
        send_dir(64, 64, 64, 11585, 0, 11585);    // x against z tie
        send_dir(0, 0, 0, 0, 0, 0);               // never steps
        send_dir(32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 16384, 16384, 16384);
        send_dir(32'sh80000000, 32'sh80000000, 32'sh80000000, -16384, -16384, -16384);
        send_dir(127, -129, 128, -32768, 32767, 1);
        send_dir(255, -1, 1, 1, -1, -32767);
        send_dir(32'sh7FFFFF80, 0, 0, 16384, 0, 0); // coordinate wrap
        // Longest reach with an axis-aligned ray and a slow oblique ray.
        set_reach(12'hFFF);
        send_dir(0, 0, 0, 16384, 0, 0);
        send_dir(0, 0, 0, 200, 300, -400);
        // Zero reach emits nothing.
        set_reach(12'd0);
        send_dir(0, 0, 0, 16384, 0, 0);
        send_random();
        set_reach(12'd1);
        send_dir(0, 0, 0, 16384, 0, 0);
        send_dir(100, 0, 0, -16384, 0, 0);
        // Hold the receiver off a while so the sender sees back-pressure.
        pop_hold = 1;
        fork
            repeat (4) send_random();
            begin
                repeat (400) @(negedge clk);
                pop_hold = 0;
            end
        join

        // Random rays across several reach settings.
        for (k = 0; k < 270; k++) begin
            if (k % 45 == 0) begin
                case ($urandom_range(4))
                    0: set_reach(12'hFFF);
                    1: set_reach(12'd0);
                    2: set_reach(ReachW'($urandom_range(1, 64)));
                    default: set_reach(ReachW'($urandom()));
                endcase
            end
            send_random();
        end

        push <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (300) @(posedge clk);

        $display("Sent %0d rays and checked %0d voxels,", rays_sent, voxels_seen);
        $display("covering zero, tiny and full reach with sender and receiver stalls.");
        if (errors == 0 && pending == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        #100ms;
        $display("DONE: errors detected");
        $finish;
    end
endmodule

>>> sim.f
+incdir+sv
sv/vrt_pkg.sv
sv/vrt_front.sv
sv/vrt_back.sv
sv/voxel_ray_traversal.sv
tb/voxel_walk_checker.sv
tb/voxel_ray_traversal_tb.sv
